### design/wmrdm_pkg.sv
// ----------------------------------------------------------------------------
// wmrdm_pkg
// Types and constants shared by the windowed message rate and delay monitor.
// ----------------------------------------------------------------------------
package wmrdm_pkg;

	localparam int STAMP_W   = 48;
	localparam int DELAY_W   = 32;
	localparam int WINDOW_W  = 27;
	localparam int TOL_W     = 24;
	localparam int LIMIT_W   = 28;
	localparam int RATE_W    = 36;
	localparam int MEAN_W    = 40;
	localparam int ENTRY_W   = 9;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 32;
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 88;

	// 1e6 microseconds per second, times 256 for eight fraction bits.
	localparam int SCALE_W = 28;
	localparam logic [SCALE_W-1:0] RATE_SCALE = 28'd256000000;
	localparam logic [RATE_W-1:0]  RATE_MAX   = '1;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 27'd1000000;
	localparam logic [TOL_W-1:0]    TOL_RESET    = 24'd100000;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL    = 8'd1;

	localparam logic OP_PUT   = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUT_RD,
		ST_PUT_DROP,
		ST_PUT_WR,
		ST_EV_RD,
		ST_EV_CHK,
		ST_CHECK,
		ST_DIV_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

### design/windowed_message_rate_delay_monitor_top.sv
// ----------------------------------------------------------------------------
// windowed_message_rate_delay_monitor_top
// Sliding-window message rate and mean delay monitor over a ring buffer.
// ----------------------------------------------------------------------------
// An item takes one transfer at a time. A check goes through ST_CHECK and
// ST_DIV_LOAD; a put through ST_PUT_RD, ST_PUT_DROP when the oldest entry is
// overwritten, ST_PUT_WR and the eviction walk, which stops when it keeps an
// entry or one entry is left, then ST_DIV_LOAD. Both then run the two
// bit-serial divisions (rate and mean) side by side, each over
// 40 + clog2(DEPTH+1) quotient bits (49 for DEPTH = 256), and end in ST_DONE.
// The timestamps and delays live in two RAMs with registered reads, so each
// eviction step reads the oldest entry in one state and tests it in the next.
// The next input transfer is taken while a finished result still waits on the output.
module windowed_message_rate_delay_monitor_top #(
	parameter int DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [127:0] s_tdata,   // timestamp[47:0], delay[79:48], now_time[127:80]
	input  logic        s_tuser,    // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,    // rate_hz_q8[35:0], mean_delay_q8[75:36],
	                                // entry_count[84:76], zero fill
	output logic        m_tuser,    // link_lost
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int TOT_W = wmrdm_pkg::DELAY_W + CW;
	localparam int NUM_W = TOT_W + 8;
	localparam int RN_W  = wmrdm_pkg::SCALE_W + CW;
	localparam int STEP_W = $clog2(NUM_W + 1);
	localparam int SW    = wmrdm_pkg::STAMP_W;

	wmrdm_pkg::state_t state_q, state_d;

	logic [wmrdm_pkg::WINDOW_W-1:0] window_q;
	logic [wmrdm_pkg::TOL_W-1:0]    tol_q;
	logic [wmrdm_pkg::LIMIT_W-1:0]  limit;

	logic                           op_q;
	logic [SW-1:0]                  ts_q;
	logic [wmrdm_pkg::DELAY_W-1:0]  dl_q;
	logic [SW-1:0]                  now_q;

	logic [AW-1:0]    head_q, tail_q;
	logic [CW-1:0]    count_q;
	logic [TOT_W-1:0] total_q;
	logic [SW-1:0]    newest_q, oldest_q;
	logic             lost_q;

	logic [SW-1:0]                 stamp_rd;
	logic [wmrdm_pkg::DELAY_W-1:0] delay_rd;
	logic                          ram_we;

	// Divider registers: the numerator register collects the quotient bits.
	logic [NUM_W-1:0]  rnum_q, mnum_q;
	logic [SW-1:0]     rrem_q, span_q;
	logic [CW-1:0]     mrem_q;
	logic [STEP_W-1:0] step_q;
	logic              rate_zero_q, rate_sat_q, mean_zero_q;

	logic              m_valid_q;
	logic [wmrdm_pkg::RATE_W-1:0]  rate_q;
	logic [wmrdm_pkg::MEAN_W-1:0]  mean_q;
	logic [wmrdm_pkg::ENTRY_W-1:0] entry_q;
	logic                          lost_out_q;

	logic full, many, keep, out_free, stale;
	logic [SW-1:0] age, elapsed;
	logic [SW:0]   rtrial;
	logic [CW:0]   mtrial;
	logic          rbit, mbit;
	logic [RN_W-1:0] rate_num;
	logic [RN_W+wmrdm_pkg::RATE_W-1:0] rq_ext;
	logic [CW+wmrdm_pkg::ENTRY_W-1:0]  cnt_ext;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign limit    = wmrdm_pkg::LIMIT_W'(window_q) + wmrdm_pkg::LIMIT_W'(tol_q);
	assign full     = (count_q == CW'(DEPTH));
	assign many     = (count_q > CW'(1));
	assign age      = newest_q - stamp_rd;
	assign keep     = (newest_q >= stamp_rd) && (age <= SW'(limit));
	assign elapsed  = (now_q >= newest_q) ? now_q - newest_q : '0;
	assign stale    = (count_q != '0) && (elapsed > SW'(limit));
	assign out_free = !m_valid_q || m_tready;

	assign rtrial = {rrem_q, rnum_q[NUM_W-1]};
	assign rbit   = (rtrial >= {1'b0, span_q});
	assign mtrial = {mrem_q, mnum_q[NUM_W-1]};
	assign mbit   = (mtrial >= {1'b0, count_q});

	assign rate_num = RN_W'(wmrdm_pkg::RATE_SCALE) * RN_W'(count_q - 1'b1);
	assign rq_ext   = (RN_W + wmrdm_pkg::RATE_W)'(rnum_q[RN_W-1:0]);
	assign cnt_ext  = (CW + wmrdm_pkg::ENTRY_W)'(count_q);

	wmrdm_ram #(.WIDTH(wmrdm_pkg::STAMP_W), .DEPTH(DEPTH)) u_stamp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (ts_q),
		.raddr (tail_q),
		.rdata (stamp_rd)
	);

	wmrdm_ram #(.WIDTH(wmrdm_pkg::DELAY_W), .DEPTH(DEPTH)) u_delay_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (dl_q),
		.raddr (tail_q),
		.rdata (delay_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wmrdm_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == wmrdm_pkg::OP_CHECK) ?
						wmrdm_pkg::ST_CHECK : wmrdm_pkg::ST_PUT_RD;
				end
			end
			wmrdm_pkg::ST_PUT_RD:   state_d = full ? wmrdm_pkg::ST_PUT_DROP : wmrdm_pkg::ST_PUT_WR;
			wmrdm_pkg::ST_PUT_DROP: state_d = wmrdm_pkg::ST_PUT_WR;
			wmrdm_pkg::ST_PUT_WR:   state_d = wmrdm_pkg::ST_EV_RD;
			wmrdm_pkg::ST_EV_RD:    state_d = many ? wmrdm_pkg::ST_EV_CHK : wmrdm_pkg::ST_DIV_LOAD;
			wmrdm_pkg::ST_EV_CHK:   state_d = keep ? wmrdm_pkg::ST_DIV_LOAD : wmrdm_pkg::ST_EV_RD;
			wmrdm_pkg::ST_CHECK:    state_d = wmrdm_pkg::ST_DIV_LOAD;
			wmrdm_pkg::ST_DIV_LOAD: state_d = wmrdm_pkg::ST_DIV;
			wmrdm_pkg::ST_DIV: begin
				if (step_q == STEP_W'(NUM_W - 1)) begin
					state_d = wmrdm_pkg::ST_DONE;
				end
			end
			wmrdm_pkg::ST_DONE:     state_d = out_free ? wmrdm_pkg::ST_IDLE : wmrdm_pkg::ST_DONE;
			default:                state_d = wmrdm_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		s_tready = 1'b0;
		ram_we   = 1'b0;
		case (state_q)
			wmrdm_pkg::ST_IDLE:   s_tready = 1'b1;
			wmrdm_pkg::ST_PUT_WR: ram_we   = 1'b1;
			default: begin
				s_tready = 1'b0;
				ram_we   = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wmrdm_pkg::ST_IDLE;
			window_q <= wmrdm_pkg::WINDOW_RESET;
			tol_q    <= wmrdm_pkg::TOL_RESET;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			total_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				if (cfg_index == wmrdm_pkg::REG_WINDOW) begin
					window_q <= cfg_data[wmrdm_pkg::WINDOW_W-1:0];
				end else if (cfg_index == wmrdm_pkg::REG_TOL) begin
					tol_q <= cfg_data[wmrdm_pkg::TOL_W-1:0];
				end
			end
			// A new result may replace one that leaves in the same cycle.
			if (state_q == wmrdm_pkg::ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				wmrdm_pkg::ST_PUT_DROP, wmrdm_pkg::ST_EV_CHK: begin
					if (state_q == wmrdm_pkg::ST_PUT_DROP || !keep) begin
						total_q <= total_q - TOT_W'(delay_rd);
						tail_q  <= next_slot(tail_q);
						count_q <= count_q - 1'b1;
					end
				end
				wmrdm_pkg::ST_PUT_WR: begin
					total_q <= total_q + TOT_W'(dl_q);
					head_q  <= next_slot(head_q);
					count_q <= count_q + 1'b1;
				end
				wmrdm_pkg::ST_CHECK: begin
					if (stale) begin
						head_q  <= '0;
						tail_q  <= '0;
						count_q <= '0;
						total_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload and datapath registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tuser;
			ts_q   <= s_tdata[47:0];
			dl_q   <= s_tdata[79:48];
			now_q  <= s_tdata[127:80];
			lost_q <= 1'b0;
		end
		case (state_q)
			wmrdm_pkg::ST_PUT_WR: newest_q <= ts_q;
			wmrdm_pkg::ST_EV_CHK: begin
				if (keep) begin
					oldest_q <= stamp_rd;
				end
			end
			wmrdm_pkg::ST_CHECK:  lost_q <= stale;
			wmrdm_pkg::ST_DIV_LOAD: begin
				rate_zero_q <= !many;
				mean_zero_q <= (count_q == '0);
				span_q      <= newest_q - oldest_q;
				rate_sat_q  <= (newest_q == oldest_q);
				rnum_q      <= NUM_W'(rate_num);
				mnum_q      <= {total_q, 8'd0};
				rrem_q      <= '0;
				mrem_q      <= '0;
				step_q      <= '0;
			end
			wmrdm_pkg::ST_DIV: begin
				rnum_q <= {rnum_q[NUM_W-2:0], rbit};
				rrem_q <= rbit ? SW'(rtrial - {1'b0, span_q}) : rtrial[SW-1:0];
				mnum_q <= {mnum_q[NUM_W-2:0], mbit};
				mrem_q <= mbit ? CW'(mtrial - {1'b0, count_q}) : mtrial[CW-1:0];
				step_q <= step_q + 1'b1;
			end
			wmrdm_pkg::ST_DONE: begin
				if (out_free) begin
					if (rate_zero_q) begin
						rate_q <= '0;
					end else if (rate_sat_q ||
						rq_ext > (RN_W + wmrdm_pkg::RATE_W)'(wmrdm_pkg::RATE_MAX)) begin
						rate_q <= wmrdm_pkg::RATE_MAX;
					end else begin
						rate_q <= rq_ext[wmrdm_pkg::RATE_W-1:0];
					end
					mean_q     <= mean_zero_q ? '0 : mnum_q[wmrdm_pkg::MEAN_W-1:0];
					entry_q    <= cnt_ext[wmrdm_pkg::ENTRY_W-1:0];
					lost_out_q <= lost_q && (op_q == wmrdm_pkg::OP_CHECK);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, entry_q, mean_q, rate_q};
	assign m_tuser  = lost_out_q;

endmodule

### design/wmrdm_ram.sv
// ----------------------------------------------------------------------------
// wmrdm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wmrdm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### verif/windowed_message_rate_delay_monitor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_message_rate_delay_monitor_top_tb
// Drives puts and link checks into the monitor and compares every result
// with a behavioral model of the timestamp ring kept in the testbench.
// ----------------------------------------------------------------------------
module windowed_message_rate_delay_monitor_top_tb;

	localparam int STAMP_W  = wmrdm_pkg::STAMP_W;
	localparam int DELAY_W  = wmrdm_pkg::DELAY_W;
	localparam int WINDOW_W = wmrdm_pkg::WINDOW_W;
	localparam int TOL_W    = wmrdm_pkg::TOL_W;
	localparam int RATE_W   = wmrdm_pkg::RATE_W;
	localparam int MEAN_W   = wmrdm_pkg::MEAN_W;
	localparam int ENTRY_W  = wmrdm_pkg::ENTRY_W;
	localparam int CFG_IDX_W = wmrdm_pkg::CFG_IDX_W;

	localparam int RING_DEPTH = 256;
	localparam int POST_CYCLES = 200;
	localparam longint CYCLE_LIMIT = 64'd3000000;

	typedef struct packed {
		logic              lost;
		logic [ENTRY_W-1:0] count;
		logic [MEAN_W-1:0]  mean;
		logic [RATE_W-1:0]  rate;
	} stats_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [127:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	windowed_message_rate_delay_monitor_top #(.DEPTH(RING_DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Model state of the monitor.
	logic [STAMP_W-1:0]  mdl_stamp [RING_DEPTH];
	logic [DELAY_W-1:0]  mdl_delay [RING_DEPTH];
	int unsigned         mdl_head, mdl_tail;
	bit                  mdl_full;
	logic [63:0]         mdl_delay_sum;
	logic [WINDOW_W-1:0] mdl_window;
	logic [TOL_W-1:0]    mdl_tol;

	stats_t expected_stats[$];
	int     fail_count = 0;
	longint cycle_count = 0;
	bit     hold_off = 1'b0;
	bit     stall_enable = 1'b1;
	logic [STAMP_W-1:0] cur_time;

	function automatic int unsigned ring_count();
		if (mdl_full)
			return RING_DEPTH;
		return (mdl_head >= mdl_tail) ? mdl_head - mdl_tail : RING_DEPTH + mdl_head - mdl_tail;
	endfunction

	function automatic int unsigned newest_idx();
		return (mdl_head == 0) ? RING_DEPTH - 1 : mdl_head - 1;
	endfunction

	function automatic void drop_oldest();
		mdl_delay_sum -= 64'(mdl_delay[mdl_tail]);
		mdl_tail = (mdl_tail + 1) % RING_DEPTH;
	endfunction

	function automatic void clear_ring();
		mdl_head = 0;
		mdl_tail = 0;
		mdl_full = 1'b0;
		mdl_delay_sum = '0;
	endfunction

	function automatic stats_t ring_stats(logic lost);
		stats_t r;
		logic [63:0] cnt, newest, oldest, span, q;
		logic [127:0] num;
		cnt = 64'(ring_count());
		r = '0;
		if (cnt > 1) begin
			newest = 64'(mdl_stamp[newest_idx()]);
			oldest = 64'(mdl_stamp[mdl_tail]);
			span = (newest >= oldest) ? newest - oldest : 64'd0;
			if (span == 0)
				r.rate = wmrdm_pkg::RATE_MAX;
			else begin
				num = 128'd256000000 * (cnt - 1);
				q = 64'(num / span);
				r.rate = (q > {28'd0, wmrdm_pkg::RATE_MAX}) ? wmrdm_pkg::RATE_MAX :
					q[RATE_W-1:0];
			end
		end
		if (cnt > 0) begin
			num = {56'd0, mdl_delay_sum, 8'd0};
			num = num / cnt;
			r.mean = num[MEAN_W-1:0];
		end
		r.count = cnt[ENTRY_W-1:0];
		r.lost = lost;
		return r;
	endfunction

	function automatic stats_t monitor_step(logic op, logic [STAMP_W-1:0] ts,
			logic [DELAY_W-1:0] dl, logic [STAMP_W-1:0] now_t);
		logic [63:0] limit, newest, oldest, elapsed;
		logic lost;
		lost = 1'b0;
		limit = 64'(mdl_window) + 64'(mdl_tol);
		if (op == wmrdm_pkg::OP_PUT) begin
			if (mdl_full)
				drop_oldest();
			mdl_stamp[mdl_head] = ts;
			mdl_delay[mdl_head] = dl;
			mdl_delay_sum += 64'(dl);
			mdl_head = (mdl_head + 1) % RING_DEPTH;
			mdl_full = (mdl_head == mdl_tail);
			while (ring_count() > 1) begin
				newest = 64'(mdl_stamp[newest_idx()]);
				oldest = 64'(mdl_stamp[mdl_tail]);
				if (newest >= oldest && newest - oldest <= limit)
					break;
				drop_oldest();
				mdl_full = 1'b0;
			end
		end else if (ring_count() > 0) begin
			newest = 64'(mdl_stamp[newest_idx()]);
			elapsed = (64'(now_t) >= newest) ? 64'(now_t) - newest : 64'd0;
			if (elapsed > limit) begin
				lost = 1'b1;
				clear_ring();
			end
		end
		return ring_stats(lost);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stall pattern, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else if (stall_enable)
			m_tready <= ($urandom_range(0, 3) != 0) || (cycle_count[7:6] == 2'b11);
		else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		stats_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{lost: m_tuser, count: m_tdata[84:76], mean: m_tdata[75:36],
				rate: m_tdata[35:0]};
			if (expected_stats.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				fail_count++;
			end else begin
				want = expected_stats.pop_front();
				if (got.rate !== want.rate)
					$display("%0t: rate expected %0d actual %0d", $time, want.rate, got.rate);
				if (got.mean !== want.mean)
					$display("%0t: mean expected %0d actual %0d", $time, want.mean, got.mean);
				if (got.count !== want.count)
					$display("%0t: count expected %0d actual %0d", $time, want.count,
						got.count);
				if (got.lost !== want.lost)
					$display("%0t: lost expected %0d actual %0d", $time, want.lost, got.lost);
				if (got !== want)
					fail_count++;
			end
		end
	end

	// Leaves tvalid high after the transfer; the caller drops it before idling.
	task automatic send_item(logic op, logic [STAMP_W-1:0] ts, logic [DELAY_W-1:0] dl,
			logic [STAMP_W-1:0] now_t);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {now_t, dl, ts};
		do @(posedge clk); while (!s_tready);
		expected_stats.push_back(monitor_step(op, ts, dl, now_t));
	endtask

	task automatic idle_input();
		s_tvalid <= 1'b0;
	endtask

	// Random burst gaps between transfers.
	task automatic send_paced(logic op, logic [STAMP_W-1:0] ts, logic [DELAY_W-1:0] dl,
			logic [STAMP_W-1:0] now_t);
		int gap;
		send_item(op, ts, dl, now_t);
		if ($urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			idle_input();
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		idle_input();
		while (expected_stats.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == wmrdm_pkg::REG_WINDOW)
			mdl_window = val[WINDOW_W-1:0];
		else if (idx == wmrdm_pkg::REG_TOL)
			mdl_tol = val[TOL_W-1:0];
		@(posedge clk);
	endtask

	task automatic test_directed();
		logic [STAMP_W-1:0] big;
		big = '1;
		send_item(wmrdm_pkg::OP_CHECK, 0, 0, 0);
		send_item(wmrdm_pkg::OP_PUT, 0, '1, 0);
		send_item(wmrdm_pkg::OP_PUT, 0, 0, 0);
		send_item(wmrdm_pkg::OP_PUT, 1, 32'h5555_aaaa, 0);
		send_item(wmrdm_pkg::OP_CHECK, 0, 0, 0);
		send_item(wmrdm_pkg::OP_CHECK, '1, '1, 1100001);
		send_item(wmrdm_pkg::OP_CHECK, 0, 0, 0);
		send_item(wmrdm_pkg::OP_PUT, 5000, 7, '1);
		send_item(wmrdm_pkg::OP_PUT, 9000, 3, 0);
		send_item(wmrdm_pkg::OP_PUT, 8000, 3, 0);
		send_item(wmrdm_pkg::OP_CHECK, 0, 0, 1109000);
		send_item(wmrdm_pkg::OP_CHECK, 0, 0, 1109001);
		send_item(wmrdm_pkg::OP_PUT, big - 10, 32'haaaa_5555, 0);
		send_item(wmrdm_pkg::OP_PUT, big, 1, 0);
		send_item(wmrdm_pkg::OP_PUT, 100, 2, 0);
		send_item(wmrdm_pkg::OP_CHECK, 0, 0, big);
		wait_drained();
	endtask

	task automatic test_config_extremes();
		write_reg(wmrdm_pkg::REG_WINDOW, 32'd1);
		write_reg(wmrdm_pkg::REG_TOL, 32'd0);
		send_item(wmrdm_pkg::OP_PUT, 10, 4, 0);
		send_item(wmrdm_pkg::OP_PUT, 11, 4, 0);
		send_item(wmrdm_pkg::OP_PUT, 12, 4, 0);
		send_item(wmrdm_pkg::OP_CHECK, 0, 0, 13);
		send_item(wmrdm_pkg::OP_CHECK, 0, 0, 14);
		wait_drained();
		write_reg(8'd7, 32'hffff_ffff);
		write_reg(wmrdm_pkg::REG_WINDOW, 32'd100000000);
		write_reg(wmrdm_pkg::REG_TOL, 32'd10000000);
		send_item(wmrdm_pkg::OP_PUT, 0, 1, 0);
		send_item(wmrdm_pkg::OP_PUT, 110000000, 1, 0);
		send_item(wmrdm_pkg::OP_PUT, 110000001, 1, 0);
		send_item(wmrdm_pkg::OP_CHECK, 0, 0, 220000002);
		wait_drained();
	endtask

	// Well-formed nondecreasing streams, with occasional backward steps and
	// full-width noise so every field bit toggles.
	task automatic run_random(int n_items);
		logic [STAMP_W-1:0] ts, now_t;
		logic [DELAY_W-1:0] dl;
		logic op;
		int sel;
		for (int i = 0; i < n_items; i++) begin
			sel = $urandom_range(0, 99);
			op = ($urandom_range(0, 7) == 0) ? wmrdm_pkg::OP_CHECK : wmrdm_pkg::OP_PUT;
			if (sel < 3)
				cur_time = STAMP_W'({$urandom(), $urandom()});
			else if (sel < 6)
				cur_time = cur_time - STAMP_W'($urandom_range(0, 5000));
			else if (sel >= 12)
				cur_time = cur_time + STAMP_W'($urandom_range(0, 3000));
			ts = cur_time;
			dl = (sel[0]) ? $urandom() : $urandom_range(0, 2000);
			now_t = ($urandom_range(0, 2) == 0) ? STAMP_W'({$urandom(), $urandom()}) :
				cur_time + STAMP_W'($urandom_range(0, 8000));
			send_paced(op, ts, dl, now_t);
		end
	endtask

	task automatic test_random();
		cur_time = 48'd1000;
		write_reg(wmrdm_pkg::REG_WINDOW, 32'd300000);
		write_reg(wmrdm_pkg::REG_TOL, 32'd50000);
		run_random(600);
		wait_drained();
		write_reg(wmrdm_pkg::REG_WINDOW, 32'd4000);
		write_reg(wmrdm_pkg::REG_TOL, 32'd1000);
		run_random(400);
		wait_drained();
		write_reg(wmrdm_pkg::REG_WINDOW, 32'd1000000);
		write_reg(wmrdm_pkg::REG_TOL, 32'd100000);
		stall_enable = 1'b0;
		run_random(200);
		stall_enable = 1'b1;
		wait_drained();
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 100; i++) begin
				cur_time = cur_time + STAMP_W'($urandom_range(0, 100));
				send_item(wmrdm_pkg::OP_PUT, cur_time, $urandom(), 0);
			end
		join
		wait_drained();
	endtask

	initial begin
		clear_ring();
		mdl_window = wmrdm_pkg::WINDOW_RESET;
		mdl_tol = wmrdm_pkg::TOL_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random();
		test_backpressure();
		repeat (POST_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_stats.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
